/* rtl/integer_field_formatter_assert.svh */
// assertion macros for the integer field formatter
`ifndef INTEGER_FIELD_FORMATTER_ASSERT_SVH
`define INTEGER_FIELD_FORMATTER_ASSERT_SVH

// same-cycle implication, held off during reset
`define IFF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define IFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/iff_pkg.sv */
// shared types, constants and helpers of the integer field formatter
`default_nettype none

package iff_pkg;

  localparam int NumDigits = 22;
  localparam int DigIdxW   = $clog2(NumDigits);
  localparam int CntW      = 7;
  localparam int MaxChars  = 64;
  localparam int DecSteps  = 64;
  localparam int StepW     = 7;

  localparam logic [2:0] KindSdec  = 3'd0;
  localparam logic [2:0] KindUdec  = 3'd1;
  localparam logic [2:0] KindOct   = 3'd2;
  localparam logic [2:0] KindHexLo = 3'd3;
  localparam logic [2:0] KindHexUp = 3'd4;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharUpX   = 8'h58;
  localparam logic [7:0] CharLowX  = 8'h78;

  typedef enum logic [1:0] {
    RadixDec,
    RadixOct,
    RadixHex
  } radix_e;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSize,
    StPlan,
    StEmit
  } state_e;

  typedef logic [NumDigits-1:0][3:0] digits_t;

  typedef struct packed {
    logic   load;
    radix_e radix;
  } dig_ctrl_t;

  // field layout: run boundaries as character positions
  typedef struct packed {
    logic [CntW-1:0] lead_end;
    logic [CntW-1:0] sign_end;
    logic [CntW-1:0] pfx_end;
    logic [CntW-1:0] zero_end;
    logic [CntW-1:0] digit_end;
    logic [CntW-1:0] char_cnt;
    logic [7:0]      sign_char;
    logic [7:0]      x_char;
    logic            upper;
  } plan_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CharZero + {4'd0, d};
    end else begin
      c = (upper ? CharUpA : CharLowA) + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/integer_field_formatter.sv */
// top level of the integer field formatter: request decode, sequencer, layout
// a request runs through the conversion, sizing, layout and emit states before its first
// character strobe; decimal conversion takes 64 shift-and-add-3 steps of the shared digit unit
// output: one character per cycle; a new request is taken only once the field is out and
// busy has dropped; busy drops in the cycle the last character is out
// reset: asynchronous active low, back to idle, no strobe pending; results cannot be stalled
`default_nettype none

module integer_field_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [63:0] arg_value_i,
  input  logic        long_arg_i,
  input  logic        left_justify_i,
  input  logic        zero_fill_i,
  input  logic        force_plus_i,
  input  logic        blank_for_plus_i,
  input  logic        alternate_form_i,
  input  logic [6:0]  field_width_i,
  input  logic        has_precision_i,
  input  logic [5:0]  min_digits_i,
  output logic        strobe_o,
  output logic [7:0]  out_char_o,
  output logic        last_char_o
);
  import iff_pkg::*;

  // sequencer
  state_e state_q, state_d;
  logic   accept;
  logic   run_emit;
  logic   dig_done;
  logic   emit_done;

  // request decode at accept
  radix_e      radix_s;
  logic        signed_s;
  logic        upper_s;
  logic [63:0] val_s;
  logic [63:0] mag_s;
  logic        neg_s;

  // request fields kept for layout
  radix_e     radix_q;
  logic       upper_q, neg_q, vnz_q, signed_q;
  logic       lj_q, zf_q, plus_q, blank_q, alt_q, hasp_q;
  logic [6:0] width_q;
  logic [5:0] prec_q;

  // sizing results
  logic [DigIdxW-1:0] nd_d, nd_q;
  logic [CntW-1:0]    digcnt_d, digcnt_q;
  logic [CntW-1:0]    total_d, total_q;
  logic               sflag_d, sflag_q;
  logic [1:0]         pfx_d, pfx_q;
  logic [7:0]         sign_char_d, sign_char_q;

  // layout
  plan_t           plan_d, plan_q;
  logic [CntW-1:0] padn, lead, zp, flen;
  logic            zpad;

  dig_ctrl_t dig_ctrl;
  digits_t   digits;

  // ---------------------------------------------------------------- decode
  always_comb begin
    radix_s  = RadixDec;
    signed_s = 1'b0;
    unique case (kind_i) inside
      KindSdec: begin
        signed_s = 1'b1;
      end
      KindOct: begin
        radix_s = RadixOct;
      end
      KindHexLo, KindHexUp: begin
        radix_s = RadixHex;
      end
      default: begin
        radix_s = RadixDec;  // unsigned decimal and unused codes
      end
    endcase
  end

  assign upper_s = (kind_i == KindHexUp);

  // short arguments are sign- or zero-extended from bit 31
  assign val_s = long_arg_i ? arg_value_i :
                 {{32{signed_s & arg_value_i[31]}}, arg_value_i[31:0]};
  assign neg_s = signed_s & val_s[63];
  assign mag_s = neg_s ? (~val_s + 64'd1) : val_s;

  assign accept = start && (state_q == StIdle);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      radix_q  <= radix_s;
      upper_q  <= upper_s;
      neg_q    <= neg_s;
      vnz_q    <= (val_s != '0);
      signed_q <= signed_s;
      lj_q     <= left_justify_i;
      zf_q     <= zero_fill_i;
      plus_q   <= force_plus_i;
      blank_q  <= blank_for_plus_i;
      alt_q    <= alternate_form_i;
      hasp_q   <= has_precision_i;
      width_q  <= field_width_i;
      prec_q   <= min_digits_i;
    end
  end

  // ---------------------------------------------------------------- digit unit
  assign dig_ctrl.load  = accept;
  assign dig_ctrl.radix = radix_s;

  iff_digits u_digits (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (dig_ctrl),
    .mag_i    (mag_s),
    .digits_o (digits),
    .done_o   (dig_done)
  );

  // ---------------------------------------------------------------- sizing
  always_comb begin
    // significant digit count from the highest nonzero digit
    nd_d = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (digits[i] != 4'd0) begin
        nd_d = DigIdxW'(i + 1);
      end
    end
    // zero prints one digit unless precision zero was given
    if (nd_d == '0 && !(hasp_q && prec_q == '0)) begin
      nd_d = DigIdxW'(1);
    end

    digcnt_d = (hasp_q && ({1'b0, prec_q} > CntW'(nd_d))) ? {1'b0, prec_q} : CntW'(nd_d);

    // sign only for signed decimal, plus wins over blank
    sflag_d = neg_q | (signed_q & (plus_q | blank_q));
    if (neg_q) begin
      sign_char_d = CharMinus;
    end else if (plus_q) begin
      sign_char_d = CharPlus;
    end else begin
      sign_char_d = CharSpace;
    end

    // octal alternate always adds a zero, hex only for nonzero values
    if (alt_q && radix_q == RadixOct) begin
      pfx_d = 2'd1;
    end else if (alt_q && radix_q == RadixHex && vnz_q) begin
      pfx_d = 2'd2;
    end else begin
      pfx_d = 2'd0;
    end

    total_d = digcnt_d + CntW'(sflag_d) + CntW'(pfx_d);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StSize) begin
      nd_q        <= nd_d;
      digcnt_q    <= digcnt_d;
      total_q     <= total_d;
      sflag_q     <= sflag_d;
      pfx_q       <= pfx_d;
      sign_char_q <= sign_char_d;
    end
  end

  // ---------------------------------------------------------------- layout
  always_comb begin
    padn = (width_q > total_q) ? width_q - total_q : '0;
    flen = (width_q > total_q) ? width_q : total_q;
    // left justify disables zero fill, precision turns it into spaces
    zpad = !lj_q && zf_q && !hasp_q;
    lead = (!lj_q && !zpad) ? padn : '0;
    zp   = zpad ? padn : '0;

    plan_d.lead_end  = lead;
    plan_d.sign_end  = lead + CntW'(sflag_q);
    plan_d.pfx_end   = plan_d.sign_end + CntW'(pfx_q);
    plan_d.zero_end  = plan_d.pfx_end + zp + (digcnt_q - CntW'(nd_q));
    plan_d.digit_end = plan_d.zero_end + CntW'(nd_q);
    // overlong fields are cut at the character limit
    plan_d.char_cnt  = (flen > CntW'(MaxChars)) ? CntW'(MaxChars) : flen;
    plan_d.sign_char = sign_char_q;
    plan_d.x_char    = upper_q ? CharUpX : CharLowX;
    plan_d.upper     = upper_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StPlan) begin
      plan_q <= plan_d;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StConv;
        end
      end
      StConv: begin
        if (dig_done) begin
          state_d = StSize;
        end
      end
      StSize: begin
        state_d = StPlan;
      end
      StPlan: begin
        // an empty field returns no characters
        state_d = (plan_d.char_cnt == '0) ? StIdle : StEmit;
      end
      StEmit: begin
        if (emit_done) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    run_emit = 1'b0;
    unique case (state_q)
      StIdle: begin
        busy = 1'b0;
      end
      StEmit: begin
        run_emit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- emitter
  iff_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .run_i    (run_emit),
    .plan_i   (plan_q),
    .digits_i (digits),
    .strobe_o (strobe_o),
    .char_o   (out_char_o),
    .last_o   (last_char_o),
    .done_o   (emit_done)
  );

  // ---------------------------------------------------------------- checks
`include "integer_field_formatter_assert.svh"

  `IFF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not go busy")
  `IFF_ASSERT_NOW(a_more_busy, strobe_o && !last_char_o, busy, "field cut off mid-stream")
  `IFF_ASSERT_NEXT(a_last_gap, last_char_o, !strobe_o, "character right after last")
  `IFF_ASSERT_NEXT(a_idle_quiet, !busy, !strobe_o, "strobe without a request")
  `IFF_ASSERT_NOW(a_last_strobe, last_char_o, strobe_o, "last marker without strobe")

endmodule

`default_nettype wire

/* rtl/iff_digits.sv */
// digit unit: radix split for octal and hex, shift-and-add-3 for decimal
`default_nettype none

module iff_digits (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iff_pkg::dig_ctrl_t ctrl_i,
  input  logic [63:0]       mag_i,
  output iff_pkg::digits_t  digits_o,
  output logic              done_o
);
  import iff_pkg::*;

  localparam int DigVecW = NumDigits * 4;

  digits_t            digits_q, digits_d;
  digits_t            adj;
  logic [DigVecW-1:0] adj_v;
  logic [63:0]        bin_q, bin_d;
  logic [StepW-1:0]   steps_q, steps_d;
  logic [65:0]        oct_src;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[i] = (digits_q[i] >= 4'd5) ? digits_q[i] + 4'd3 : digits_q[i];
    end
    adj_v = adj;
  end

  assign oct_src = {2'b00, mag_i};

  always_comb begin
    digits_d = digits_q;
    bin_d    = bin_q;
    steps_d  = steps_q;
    if (ctrl_i.load) begin
      bin_d   = mag_i;
      steps_d = '0;
      unique case (ctrl_i.radix)
        RadixOct: begin
          for (int i = 0; i < NumDigits; i++) begin
            digits_d[i] = {1'b0, oct_src[3*i +: 3]};
          end
        end
        RadixHex: begin
          for (int i = 0; i < NumDigits; i++) begin
            digits_d[i] = (i < 16) ? mag_i[(4*i) % 64 +: 4] : 4'd0;
          end
        end
        default: begin
          digits_d = '0;
          steps_d  = StepW'(DecSteps);
        end
      endcase
    end else if (steps_q != '0) begin
      // correct each bcd digit, then shift one binary bit in
      digits_d = digits_t'({adj_v[DigVecW-2:0], bin_q[63]});
      bin_d    = {bin_q[62:0], 1'b0};
      steps_d  = steps_q - StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
    end else begin
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    bin_q    <= bin_d;
  end

  assign digits_o = digits_q;
  assign done_o   = (steps_q == '0);

endmodule

`default_nettype wire

/* rtl/iff_emit.sv */
// character sequencer: one field character per cycle into the output register
`default_nettype none

module iff_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             run_i,
  input  iff_pkg::plan_t   plan_i,
  input  iff_pkg::digits_t digits_i,
  output logic             strobe_o,
  output logic [7:0]       char_o,
  output logic             last_o,
  output logic             done_o
);
  import iff_pkg::*;

  logic [CntW-1:0]    pos_q, pos_d;
  logic [CntW-1:0]    didx_w;
  logic [DigIdxW-1:0] didx;
  logic [7:0]         char_d, char_q;
  logic               strobe_q, last_q, is_last;

  assign didx_w  = plan_i.digit_end - CntW'(1) - pos_q;
  assign didx    = didx_w[DigIdxW-1:0];
  assign is_last = (pos_q == plan_i.char_cnt - CntW'(1));
  assign done_o  = run_i && is_last;
  assign pos_d   = run_i ? pos_q + CntW'(1) : '0;

  always_comb begin
    if (pos_q < plan_i.lead_end) begin
      char_d = CharSpace;
    end else if (pos_q < plan_i.sign_end) begin
      char_d = plan_i.sign_char;
    end else if (pos_q < plan_i.pfx_end) begin
      char_d = (pos_q == plan_i.sign_end) ? CharZero : plan_i.x_char;
    end else if (pos_q < plan_i.zero_end) begin
      char_d = CharZero;
    end else if (pos_q < plan_i.digit_end) begin
      char_d = digit_char(digits_i[didx], plan_i.upper);
    end else begin
      char_d = CharSpace;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      strobe_q <= run_i;
      last_q   <= done_o;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign strobe_o = strobe_q;
  assign char_o   = char_q;
  assign last_o   = last_q;

endmodule

`default_nettype wire
